// File: design/svd_pkg.sv
// shared constants and types for the saccade velocity detector
`default_nettype none

package svd_pkg;

   // configuration register width and index space
   localparam int CFG_BITS       = 16;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SPEED_THRESHOLD = 3'd0,
      CSR_MIN_RUN_POINTS  = 3'd1,
      CSR_MIN_AMPLITUDE   = 3'd2,
      CSR_MIN_DURATION    = 3'd3,
      CSR_START_OFFSET    = 3'd4
   } csr_index_type;

   // run length counter saturates here
   localparam int RUN_BITS = 16;
   localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

   // response queue geometry
   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS = $clog2(RSP_DEPTH + 1);

   // up to two responses are queued per request
   typedef struct packed {
      logic first;
      logic second;
   } rsp_push_type;

endpackage

`default_nettype wire

// File: design/svd_rsp_fifo.sv
// response queue: two writes and one read per cycle
`default_nettype none

module svd_rsp_fifo import svd_pkg::*; #(
   parameter int WIDTH = 115
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rsp_push_type     push,
   input  wire logic [WIDTH-1:0] push_data0,
   input  wire logic [WIDTH-1:0] push_data1,
   output logic                  room_for_two,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   logic [WIDTH-1:0]        entry_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_BITS-1:0] count_ff, count_in;
   logic [RSP_PTR_BITS-1:0] wr_ptr_next;
   logic                    pop;
   logic [RSP_CNT_BITS-1:0] push_count;

   assign pop          = pop_valid & pop_ready;
   assign pop_valid    = (count_ff != '0);
   assign pop_data     = entry_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= RSP_CNT_BITS'(RSP_DEPTH - 2));
   assign wr_ptr_next  = wr_ptr_ff + RSP_PTR_BITS'(1);
   assign push_count   = RSP_CNT_BITS'(push.first) + RSP_CNT_BITS'(push.second);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_BITS'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + push_count - RSP_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         entry_ff[wr_ptr_ff] <= push_data0;
      end
      if (push.second) begin
         entry_ff[wr_ptr_next] <= push_data1;
      end
   end

endmodule

`default_nettype wire

// File: design/saccade_velocity_detector_top.sv
// saccade detector by velocity threshold, top level
`default_nettype none

// One signed sample is taken per request, one request per clock while the
// response queue has room for two entries. Each sample is differenced with
// the one before it in the same record; a step whose magnitude reaches
// speed_threshold is fast, and fast steps of one sign build a run. When a run
// of at least min_run_points steps ends (slow step, sign flip, or the request
// flagged end_of_record), it is reported if its step count reaches
// min_duration and its absolute amplitude reaches min_amplitude. One request
// yields zero, one or two responses; rsp_last_of_item marks the final one.
// The per-sample difference, compare and run update are combinational; each
// response is registered in a four-entry queue, so the sustained rate is one
// sample per clock unless the consumer stalls. Indices count samples from the
// start of a record and wrap. The user must write configuration through csr_*
// only while the block is idle; the block itself does not enforce this.

module saccade_velocity_detector_top import svd_pkg::*; #(
   parameter int SAMPLE_BITS = 16,
   parameter int INDEX_BITS  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample,
   input  wire logic                          req_end_of_record,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [INDEX_BITS-1:0]              rsp_begin_index,
   output logic [INDEX_BITS-1:0]              rsp_end_index,
   output logic signed [SAMPLE_BITS-1:0]      rsp_begin_value,
   output logic signed [SAMPLE_BITS-1:0]      rsp_end_value,
   output logic signed [SAMPLE_BITS:0]        rsp_amplitude,
   output logic [RUN_BITS-1:0]                rsp_step_count,
   output logic                               rsp_last_of_item,
   // configuration
   input  wire logic                          csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [CFG_BITS-1:0]           csr_write_data
);

   // compare widths wide enough for both sides
   localparam int MAG_CMP_BITS = (SAMPLE_BITS + 1 > CFG_BITS) ? SAMPLE_BITS + 1 : CFG_BITS;
   localparam int IDX_CMP_BITS = (INDEX_BITS > CFG_BITS) ? INDEX_BITS : CFG_BITS;

   typedef struct packed {
      logic [INDEX_BITS-1:0]         begin_index;
      logic [INDEX_BITS-1:0]         end_index;
      logic signed [SAMPLE_BITS-1:0] begin_value;
      logic signed [SAMPLE_BITS-1:0] end_value;
      logic signed [SAMPLE_BITS:0]   amplitude;
      logic [RUN_BITS-1:0]           step_count;
      logic                          last_of_item;
   } rsp_type;

   localparam int RSP_BITS = $bits(rsp_type);

   // configuration registers
   logic [CFG_BITS-1:0] speed_threshold_ff;
   logic [CFG_BITS-1:0] min_run_points_ff;
   logic [CFG_BITS-1:0] min_amplitude_ff;
   logic [CFG_BITS-1:0] min_duration_ff;
   logic [CFG_BITS-1:0] start_offset_ff;

   // record state
   logic                   have_prev_ff,   have_prev_in;
   logic                   primed_ff,      primed_in;
   logic                   prev_rising_ff, prev_rising_in;
   logic [SAMPLE_BITS-1:0] prev_sample_ff, prev_sample_in;
   logic [INDEX_BITS-1:0]  sample_idx_ff,  sample_idx_in;
   logic [RUN_BITS-1:0]    run_len_ff,     run_len_in;
   logic [INDEX_BITS-1:0]  run_bidx_ff,    run_bidx_in;
   logic [SAMPLE_BITS-1:0] run_bval_ff,    run_bval_in;

   // per-request datapath
   logic                          accept;
   logic [INDEX_BITS-1:0]         cur_idx;
   logic signed [SAMPLE_BITS:0]   diff;
   logic [SAMPLE_BITS:0]          diff_mag;
   logic                          rising;
   logic                          fast;
   logic                          eff_rising;
   logic                          active;
   logic                          run_extends;
   logic signed [SAMPLE_BITS:0]   amp_a;
   logic [SAMPLE_BITS:0]          mag_a;
   logic                          emit_a;
   logic [RUN_BITS-1:0]           run_len_nx;
   logic [INDEX_BITS-1:0]         run_bidx_nx;
   logic [SAMPLE_BITS-1:0]        run_bval_nx;
   logic signed [SAMPLE_BITS:0]   amp_b;
   logic [SAMPLE_BITS:0]          mag_b;
   logic                          emit_b;
   rsp_type                       rsp_a;
   rsp_type                       rsp_b;
   rsp_type                       rsp_head;
   rsp_push_type                  push;
   logic                          room_for_two;
   logic [RSP_BITS-1:0]           head_bits;

   assign accept    = req_valid & req_ready;
   assign req_ready = room_for_two;

   // configuration writes, unknown indices dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_threshold_ff <= CFG_BITS'(1);
         min_run_points_ff  <= CFG_BITS'(1);
         min_amplitude_ff   <= CFG_BITS'(1);
         min_duration_ff    <= CFG_BITS'(1);
         start_offset_ff    <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SPEED_THRESHOLD: speed_threshold_ff <= csr_write_data;
            CSR_MIN_RUN_POINTS:  min_run_points_ff  <= csr_write_data;
            CSR_MIN_AMPLITUDE:   min_amplitude_ff   <= csr_write_data;
            CSR_MIN_DURATION:    min_duration_ff    <= csr_write_data;
            CSR_START_OFFSET:    start_offset_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      // index of this sample within the record
      cur_idx = have_prev_ff ? sample_idx_ff + INDEX_BITS'(1) : '0;

      // step from the previous sample
      diff     = $signed({req_sample[SAMPLE_BITS-1], req_sample})
               - $signed({prev_sample_ff[SAMPLE_BITS-1], prev_sample_ff});
      diff_mag = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : (SAMPLE_BITS+1)'(diff);
      rising   = !diff[SAMPLE_BITS] && (diff != '0);
      fast     = MAG_CMP_BITS'(diff_mag) >= MAG_CMP_BITS'(speed_threshold_ff);

      // first step of a record sets the reference sign
      eff_rising = primed_ff ? prev_rising_ff : rising;
      // step index is the previous sample's index
      active  = have_prev_ff
              && (IDX_CMP_BITS'(sample_idx_ff) >= IDX_CMP_BITS'(start_offset_ff));
      run_extends = fast && (rising == eff_rising) && (run_len_ff != '0);

      // run closed by this step, ends at the previous sample
      amp_a  = $signed({prev_sample_ff[SAMPLE_BITS-1], prev_sample_ff})
             - $signed({run_bval_ff[SAMPLE_BITS-1], run_bval_ff});
      mag_a  = amp_a[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-amp_a) : (SAMPLE_BITS+1)'(amp_a);
      emit_a = active && !run_extends
             && (run_len_ff != '0) && (run_len_ff >= min_run_points_ff)
             && (run_len_ff >= min_duration_ff)
             && (MAG_CMP_BITS'(mag_a) >= MAG_CMP_BITS'(min_amplitude_ff));

      // run update
      run_len_nx  = run_len_ff;
      run_bidx_nx = run_bidx_ff;
      run_bval_nx = run_bval_ff;
      if (active) begin
         if (fast) begin
            if (run_extends) begin
               if (run_len_ff != RUN_MAX) begin
                  run_len_nx = run_len_ff + RUN_BITS'(1);
               end
            end else begin
               run_len_nx  = RUN_BITS'(1);
               run_bidx_nx = sample_idx_ff;
               run_bval_nx = prev_sample_ff;
            end
         end else begin
            run_len_nx = '0;
         end
      end

      // run still open at the record end closes on this sample
      amp_b  = $signed({req_sample[SAMPLE_BITS-1], req_sample})
             - $signed({run_bval_nx[SAMPLE_BITS-1], run_bval_nx});
      mag_b  = amp_b[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-amp_b) : (SAMPLE_BITS+1)'(amp_b);
      emit_b = req_end_of_record
             && (run_len_nx != '0) && (run_len_nx >= min_run_points_ff)
             && (run_len_nx >= min_duration_ff)
             && (MAG_CMP_BITS'(mag_b) >= MAG_CMP_BITS'(min_amplitude_ff));

      rsp_a.begin_index  = run_bidx_ff;
      rsp_a.end_index    = sample_idx_ff;
      rsp_a.begin_value  = run_bval_ff;
      rsp_a.end_value    = prev_sample_ff;
      rsp_a.amplitude    = amp_a;
      rsp_a.step_count   = run_len_ff;
      rsp_a.last_of_item = !emit_b;

      rsp_b.begin_index  = run_bidx_nx;
      rsp_b.end_index    = cur_idx;
      rsp_b.begin_value  = run_bval_nx;
      rsp_b.end_value    = req_sample;
      rsp_b.amplitude    = amp_b;
      rsp_b.step_count   = run_len_nx;
      rsp_b.last_of_item = 1'b1;

      // queue order: closed run first, then record-end run
      push.first  = accept && (emit_a || emit_b);
      push.second = accept && emit_a && emit_b;

      // next record state
      have_prev_in   = have_prev_ff;
      primed_in      = primed_ff;
      prev_rising_in = prev_rising_ff;
      prev_sample_in = prev_sample_ff;
      sample_idx_in  = sample_idx_ff;
      run_len_in     = run_len_ff;
      run_bidx_in    = run_bidx_ff;
      run_bval_in    = run_bval_ff;
      if (accept) begin
         if (req_end_of_record) begin
            have_prev_in   = 1'b0;
            primed_in      = 1'b0;
            prev_rising_in = 1'b0;
            prev_sample_in = '0;
            sample_idx_in  = '0;
            run_len_in     = '0;
            run_bidx_in    = '0;
            run_bval_in    = '0;
         end else begin
            have_prev_in   = 1'b1;
            prev_sample_in = req_sample;
            sample_idx_in  = cur_idx;
            run_len_in     = run_len_nx;
            run_bidx_in    = run_bidx_nx;
            run_bval_in    = run_bval_nx;
            if (have_prev_ff) begin
               primed_in      = 1'b1;
               prev_rising_in = active ? rising : eff_rising;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff   <= 1'b0;
         primed_ff      <= 1'b0;
         prev_rising_ff <= 1'b0;
         prev_sample_ff <= '0;
         sample_idx_ff  <= '0;
         run_len_ff     <= '0;
         run_bidx_ff    <= '0;
         run_bval_ff    <= '0;
      end else begin
         have_prev_ff   <= have_prev_in;
         primed_ff      <= primed_in;
         prev_rising_ff <= prev_rising_in;
         prev_sample_ff <= prev_sample_in;
         sample_idx_ff  <= sample_idx_in;
         run_len_ff     <= run_len_in;
         run_bidx_ff    <= run_bidx_in;
         run_bval_ff    <= run_bval_in;
      end
   end

   // response queue decouples the two sides
   svd_rsp_fifo #(
      .WIDTH (RSP_BITS)
   ) u_rsp_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_data0   (emit_a ? rsp_a : rsp_b),
      .push_data1   (rsp_b),
      .room_for_two (room_for_two),
      .pop_valid    (rsp_valid),
      .pop_ready    (rsp_ready),
      .pop_data     (head_bits)
   );

   assign rsp_head         = rsp_type'(head_bits);
   assign rsp_begin_index  = rsp_head.begin_index;
   assign rsp_end_index    = rsp_head.end_index;
   assign rsp_begin_value  = rsp_head.begin_value;
   assign rsp_end_value    = rsp_head.end_value;
   assign rsp_amplitude    = rsp_head.amplitude;
   assign rsp_step_count   = rsp_head.step_count;
   assign rsp_last_of_item = rsp_head.last_of_item;

`ifndef SYNTHESIS
   // record end returns the record state to its idle form
   a_record_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_record) |=> (!have_prev_ff && run_len_ff == '0 && !primed_ff))
      else $error("record state not cleared after record end");

   // a run only exists inside a record that has a previous sample
   a_run_in_record: assert property (@(posedge clock) disable iff (reset)
      (run_len_ff != '0) |-> have_prev_ff)
      else $error("open run without a previous sample");

   // the second queue write always pairs with a first
   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push.second |-> push.first)
      else $error("second response queued without the first");

   // responses are only queued for an accepted request
   a_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      push.first |-> accept)
      else $error("response queued without a request");
`endif

endmodule

`default_nettype wire
